[src/tsp_pkg.sv]
// Shared types and constants for the thermoelastic stress point.
`timescale 1ns / 1ps

package tsp_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_STIFFNESS_MPA   = 3'd0;
    localparam logic [2:0] REG_RATIO_BASE      = 3'd1;
    localparam logic [2:0] REG_EXPANSION_BASE  = 3'd2;
    localparam logic [2:0] REG_STIFFNESS_SLOPE = 3'd3;
    localparam logic [2:0] REG_RATIO_SLOPE     = 3'd4;
    localparam logic [2:0] REG_EXPANSION_SLOPE = 3'd5;
    localparam logic [2:0] REG_REFERENCE_TEMP  = 3'd6;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_STIFF = 2'd1,
        ERR_RATIO = 2'd2
    } err_code_t;

    typedef struct packed {
        logic signed [31:0] strain_radial;
        logic signed [31:0] strain_axial;
        logic signed [31:0] strain_circ;
        logic signed [31:0] strain_shear;
        logic        [17:0] temp_now;
    } in_word_t;

    typedef struct packed {
        logic signed [47:0] stress_radial;
        logic signed [47:0] stress_axial;
        logic signed [47:0] stress_circ;
        logic signed [47:0] stress_shear;
        logic        [1:0]  error_code;
    } out_word_t;

endpackage

[src/thermoelastic_stress_point.sv]
// Thermoelastic stress point: pipelined Hooke law with temperature-dependent properties.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  input    | in_valid / in_stall | in_word: four strains, temperature
//  output   | out_valid/out_stall | out_word: four stresses, error code
//  config   | cfg_write           | cfg_index, cfg_data (write only)
//
// One word enters per cycle while in_stall is low. The 48-step restoring divider, one
// quotient bit per stage, forms each stress. Reset clears all valid bits and loads the
// register defaults. A stalled output holds its word; upstream stages keep moving while
// the stage in front of the output register is empty, so one bubble is absorbed before
// in_stall rises.
`timescale 1ns / 1ps

module thermoelastic_stress_point
    import tsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int DIV_BITS = 48;
    localparam int S_IN     = 0;
    localparam int S_PROP   = 1;
    localparam int S_THERM  = 2;
    localparam int S_EL     = 3;
    localparam int S_PROD   = 4;
    localparam int S_SUM    = 5;
    localparam int S_ABS    = 6;
    localparam int S_PP     = 7;
    localparam int S_ROW    = 8;
    localparam int S_T      = 9;
    localparam int S_PRE    = 10;
    localparam int S_OUT    = S_PRE + DIV_BITS + 1;
    localparam int NS       = S_OUT + 1;

    typedef struct packed {
        logic [1:0]  err;
        logic [3:0]  neg;
        logic [3:0]  sat;
        logic [61:0] d;
    } div_side_t;

    function automatic logic [62:0] div_step(input logic [61:0] rem, input logic nb,
                                             input logic [61:0] dd);
        logic [62:0] r;
        logic [62:0] t;
        r = {rem, nb};
        t = r - {1'b0, dd};
        if (r >= {1'b0, dd})
            return {1'b1, t[61:0]};
        else
            return {1'b0, r[61:0]};
    endfunction

    // Configuration registers.
    logic        [19:0] stiffness_mpa_reg;
    logic signed [16:0] ratio_base_reg;
    logic signed [31:0] expansion_base_reg;
    logic signed [31:0] stiffness_slope_reg;
    logic signed [31:0] ratio_slope_reg;
    logic signed [31:0] expansion_slope_reg;
    logic        [17:0] reference_temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_mpa_reg   <= 20'd200000;
            ratio_base_reg      <= 17'sd19661;
            expansion_base_reg  <= 32'sd10995116;
            stiffness_slope_reg <= '0;
            ratio_slope_reg     <= '0;
            expansion_slope_reg <= '0;
            reference_temp_reg  <= 18'd19200;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STIFFNESS_MPA:   stiffness_mpa_reg   <= cfg_data[19:0];
                REG_RATIO_BASE:      ratio_base_reg      <= cfg_data[16:0];
                REG_EXPANSION_BASE:  expansion_base_reg  <= cfg_data;
                REG_STIFFNESS_SLOPE: stiffness_slope_reg <= cfg_data;
                REG_RATIO_SLOPE:     ratio_slope_reg     <= cfg_data;
                REG_EXPANSION_SLOPE: expansion_slope_reg <= cfg_data;
                REG_REFERENCE_TEMP:  reference_temp_reg  <= cfg_data[17:0];
                default: ;
            endcase
        end
    end

    // Pipeline control.
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic          adv;
    logic          adv_out;

    assign adv_out  = !v_reg[S_OUT] || !out_stall;
    assign adv      = adv_out || !v_reg[S_OUT-1];
    assign in_stall = !adv;

    always_comb
    begin
        v_next = v_reg;
        if (adv)
            v_next[S_OUT-1:0] = {v_reg[S_OUT-2:0], in_valid};
        if (adv_out)
            v_next[S_OUT] = v_reg[S_OUT-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // Stage 0: input capture.
    in_word_t s0_word_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            s0_word_reg <= in_word;
    end

    // Stage 1: temperature-dependent properties.
    logic signed [18:0] dt;
    logic signed [50:0] es_dt;
    logic signed [50:0] ns_dt;
    logic signed [50:0] as_dt;
    logic signed [51:0] e_base;
    logic signed [51:0] nu_base;
    logic signed [54:0] a_base;
    logic signed [51:0] s1_e_reg;
    logic signed [51:0] s1_nu_reg;
    logic signed [54:0] s1_a_reg;
    logic signed [18:0] s1_dt_reg;
    logic signed [31:0] s1_strain_reg [4];

    assign dt      = $signed({1'b0, s0_word_reg.temp_now}) - $signed({1'b0, reference_temp_reg});
    assign es_dt   = stiffness_slope_reg * dt;
    assign ns_dt   = ratio_slope_reg * dt;
    assign as_dt   = expansion_slope_reg * dt;
    assign e_base  = $signed({18'd0, stiffness_mpa_reg, 14'd0});
    assign nu_base = $signed({{13{ratio_base_reg[16]}}, ratio_base_reg, 22'd0});
    assign a_base  = $signed({expansion_base_reg[31], expansion_base_reg, 22'd0});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_e_reg         <= e_base + 52'(es_dt);
            s1_nu_reg        <= nu_base + 52'(ns_dt);
            s1_a_reg         <= a_base + 55'(as_dt);
            s1_dt_reg        <= dt;
            s1_strain_reg[0] <= s0_word_reg.strain_radial;
            s1_strain_reg[1] <= s0_word_reg.strain_axial;
            s1_strain_reg[2] <= s0_word_reg.strain_circ;
            s1_strain_reg[3] <= s0_word_reg.strain_shear;
        end
    end

    // Stage 2: checks, thermal strain, ratio terms.
    logic signed [73:0] a_dt;
    logic        [1:0]  err_next;
    logic signed [30:0] nu30_raw;
    logic signed [30:0] nu30;
    logic signed [31:0] p_full;
    logic signed [32:0] q_full;
    logic        [1:0]  s2_err_reg;
    logic signed [35:0] s2_th_reg;
    logic signed [30:0] s2_nu30_reg;
    logic        [30:0] s2_p_reg;
    logic        [31:0] s2_q_reg;
    logic        [49:0] s2_e_reg;
    logic signed [31:0] s2_strain_reg [4];

    assign a_dt     = s1_a_reg * s1_dt_reg;
    assign nu30_raw = s1_nu_reg[38:8];
    // A ratio that floors onto minus one is nudged up one step so that 1 + nu stays positive.
    assign nu30     = (nu30_raw == {1'b1, 30'd0}) ? $signed({1'b1, 29'd0, 1'b1}) : nu30_raw;
    assign p_full   = 32'sh4000_0000 + 32'(nu30);
    assign q_full   = 33'sh0_4000_0000 - $signed({nu30[30], nu30, 1'b0});

    always_comb
    begin
        if (stiffness_mpa_reg == '0)
            err_next = ERR_STIFF;
        else if (ratio_base_reg == 17'sh10000 || (!ratio_base_reg[16] && ratio_base_reg[15]))
            err_next = ERR_RATIO;
        else if (s1_e_reg <= 52'sd0)
            err_next = ERR_STIFF;
        else if (s1_nu_reg <= -(52'sd1 <<< 38) || s1_nu_reg >= (52'sd1 <<< 37))
            err_next = ERR_RATIO;
        else
            err_next = ERR_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_err_reg    <= err_next;
            s2_th_reg     <= a_dt[73:38];
            s2_nu30_reg   <= nu30;
            s2_p_reg      <= p_full[30:0];
            s2_q_reg      <= q_full[31:0];
            s2_e_reg      <= s1_e_reg[49:0];
            s2_strain_reg <= s1_strain_reg;
        end
    end

    // Stage 3: elastic strains, trace, divisor.
    logic        [62:0] pq;
    logic        [1:0]  s3_err_reg;
    logic signed [30:0] s3_nu30_reg;
    logic        [31:0] s3_q_reg;
    logic        [49:0] s3_e_reg;
    logic        [61:0] s3_d_reg;
    logic signed [36:0] s3_el_reg [3];
    logic signed [38:0] s3_tr_reg;
    logic signed [31:0] s3_shear_reg;
    logic signed [36:0] el [3];

    assign pq = s2_p_reg * s2_q_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            el[l] = 37'(s2_strain_reg[l]) - 37'(s2_th_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_err_reg   <= s2_err_reg;
            s3_nu30_reg  <= s2_nu30_reg;
            s3_q_reg     <= s2_q_reg;
            s3_e_reg     <= s2_e_reg;
            s3_d_reg     <= pq[61:0];
            s3_el_reg    <= el;
            s3_tr_reg    <= 39'(el[0]) + 39'(el[1]) + 39'(el[2]);
            s3_shear_reg <= s2_strain_reg[3];
        end
    end

    // Stage 4: numerator products.
    logic signed [32:0] q_s;
    logic signed [69:0] s4_nt_reg;
    logic signed [69:0] s4_qe_reg [3];
    logic signed [64:0] s4_sh_reg;
    logic        [1:0]  s4_err_reg;
    logic        [49:0] s4_e_reg;
    logic        [61:0] s4_d_reg;

    assign q_s = $signed({1'b0, s3_q_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_nt_reg <= s3_nu30_reg * s3_tr_reg;
            for (int l = 0; l < 3; l++)
                s4_qe_reg[l] <= q_s * s3_el_reg[l];
            s4_sh_reg  <= q_s * s3_shear_reg;
            s4_err_reg <= s3_err_reg;
            s4_e_reg   <= s3_e_reg;
            s4_d_reg   <= s3_d_reg;
        end
    end

    // Stage 5: numerator sums.
    logic signed [70:0] s5_n_reg [4];
    logic        [1:0]  s5_err_reg;
    logic        [49:0] s5_e_reg;
    logic        [61:0] s5_d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
                s5_n_reg[l] <= 71'(s4_nt_reg) + 71'(s4_qe_reg[l]);
            s5_n_reg[3] <= 71'(s4_sh_reg);
            s5_err_reg  <= s4_err_reg;
            s5_e_reg    <= s4_e_reg;
            s5_d_reg    <= s4_d_reg;
        end
    end

    // Stage 6: sign and magnitude.
    logic [69:0] s6_mag_reg [4];
    logic [3:0]  s6_neg_reg;
    logic [1:0]  s6_err_reg;
    logic [49:0] s6_e_reg;
    logic [61:0] s6_d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
            begin
                s6_neg_reg[l] <= s5_n_reg[l][70];
                s6_mag_reg[l] <= s5_n_reg[l][70] ? 70'(-s5_n_reg[l]) : s5_n_reg[l][69:0];
            end
            s6_err_reg <= s5_err_reg;
            s6_e_reg   <= s5_e_reg;
            s6_d_reg   <= s5_d_reg;
        end
    end

    // Stage 7: partial products of magnitude times stiffness, 24 by 25 bits each.
    logic [48:0] s7_pp_reg [4][3][2];
    logic [3:0]  s7_neg_reg;
    logic [1:0]  s7_err_reg;
    logic [61:0] s7_d_reg;
    logic [23:0] mpart [4][3];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            mpart[l][0] = s6_mag_reg[l][23:0];
            mpart[l][1] = s6_mag_reg[l][47:24];
            mpart[l][2] = {2'd0, s6_mag_reg[l][69:48]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s7_pp_reg[l][k][0] <= mpart[l][k] * s6_e_reg[24:0];
                    s7_pp_reg[l][k][1] <= mpart[l][k] * s6_e_reg[49:25];
                end
            end
            s7_neg_reg <= s6_neg_reg;
            s7_err_reg <= s6_err_reg;
            s7_d_reg   <= s6_d_reg;
        end
    end

    // Stage 8: one row per piece of the magnitude.
    logic [73:0] s8_row_reg [4][3];
    logic [3:0]  s8_neg_reg;
    logic [1:0]  s8_err_reg;
    logic [61:0] s8_d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
                for (int k = 0; k < 3; k++)
                    s8_row_reg[l][k] <= 74'(s7_pp_reg[l][k][0])
                                      + {s7_pp_reg[l][k][1], 25'd0};
            s8_neg_reg <= s7_neg_reg;
            s8_err_reg <= s7_err_reg;
            s8_d_reg   <= s7_d_reg;
        end
    end

    // Stage 9: dividend = 4 * |N| * E plus half the divisor for rounding.
    logic [123:0] s9_t_reg [4];
    logic [3:0]   s9_neg_reg;
    logic [1:0]   s9_err_reg;
    logic [61:0]  s9_d_reg;
    logic [121:0] prod_sum [4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
            prod_sum[l] = 122'(s8_row_reg[l][0]) + {24'd0, s8_row_reg[l][1], 24'd0}
                        + {s8_row_reg[l][2], 48'd0};
    end

    function automatic logic [60:0] s9_d_half(input logic [61:0] dd);
        return dd[61:1];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
                s9_t_reg[l] <= {prod_sum[l], 2'd0} + {63'd0, s9_d_half(s8_d_reg)};
            s9_neg_reg <= s8_neg_reg;
            s9_err_reg <= s8_err_reg;
            s9_d_reg   <= s8_d_reg;
        end
    end

    // Stage 10 and the divider: restoring division, one quotient bit per stage.
    logic [61:0]         dv_rem_reg  [DIV_BITS+1][4];
    logic [DIV_BITS-1:0] dv_low_reg  [DIV_BITS+1][4];
    logic [DIV_BITS-1:0] dv_quo_reg  [DIV_BITS+1][4];
    div_side_t           dv_side_reg [DIV_BITS+1];
    logic [3:0]          pre_sat;
    logic [62:0]         step_res    [DIV_BITS][4];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
            pre_sat[l] = s9_t_reg[l][123:48] >= {14'd0, s9_d_reg};
        for (int j = 0; j < DIV_BITS; j++)
            for (int l = 0; l < 4; l++)
                step_res[j][l] = div_step(dv_rem_reg[j][l], dv_low_reg[j][l][DIV_BITS-1],
                                          dv_side_reg[j].d);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 4; l++)
            begin
                dv_rem_reg[0][l] <= s9_t_reg[l][109:48];
                dv_low_reg[0][l] <= s9_t_reg[l][47:0];
                dv_quo_reg[0][l] <= '0;
            end
            dv_side_reg[0].err <= s9_err_reg;
            dv_side_reg[0].neg <= s9_neg_reg;
            dv_side_reg[0].sat <= pre_sat;
            dv_side_reg[0].d   <= s9_d_reg;
            for (int j = 0; j < DIV_BITS; j++)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    dv_rem_reg[j+1][l] <= step_res[j][l][61:0];
                    dv_low_reg[j+1][l] <= {dv_low_reg[j][l][DIV_BITS-2:0], 1'b0};
                    dv_quo_reg[j+1][l] <= {dv_quo_reg[j][l][DIV_BITS-2:0], step_res[j][l][62]};
                end
                dv_side_reg[j+1] <= dv_side_reg[j];
            end
        end
    end

    // Output stage: saturation, sign and error zeroing.
    logic [47:0]  limit     [4];
    logic [47:0]  mq        [4];
    logic [47:0]  stress    [4];
    div_side_t    last_side;
    out_word_t    out_next;
    out_word_t    out_reg;

    assign last_side = dv_side_reg[DIV_BITS];

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            limit[l] = last_side.neg[l] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
            if (last_side.sat[l] || dv_quo_reg[DIV_BITS][l] > limit[l])
                mq[l] = limit[l];
            else
                mq[l] = dv_quo_reg[DIV_BITS][l];
            if (last_side.err != ERR_NONE)
                stress[l] = '0;
            else
                stress[l] = last_side.neg[l] ? -mq[l] : mq[l];
        end
        out_next.stress_radial = stress[0];
        out_next.stress_axial  = stress[1];
        out_next.stress_circ   = stress[2];
        out_next.stress_shear  = stress[3];
        out_next.error_code    = last_side.err;
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
            out_reg <= out_next;
    end

    assign out_valid = v_reg[S_OUT];
    assign out_word  = out_reg;

    // A failed check never lets a stress through.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.error_code != ERR_NONE |->
            out_word.stress_radial == '0 && out_word.stress_axial == '0 &&
            out_word.stress_circ == '0 && out_word.stress_shear == '0)
        else $error("error word carries a nonzero stress");

    // The input is held back only when a result is waiting at a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && v_reg[S_OUT-1])
        else $error("input stalled without a full, stalled output");

    // An accepted word lands in the first stage.
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v_reg[S_IN])
        else $error("accepted word lost at the input stage");

    // Without saturation, the final remainder stays below the divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[S_OUT-1] && !last_side.sat[0] |-> dv_rem_reg[DIV_BITS][0] < last_side.d)
        else $error("divider remainder out of range");

endmodule
